// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RGBL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rgbl assertion failed");

// next-cycle implication, disabled while reset is low
`define RGBL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rgbl assertion failed");

`endif

// ===== rtl/rgbl_pkg.sv =====
package rgbl_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int CHAN_W  = 8;
  localparam int LIN_W   = 17;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = COEF_W + LIN_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int XYZ_W   = 17;
  localparam int ROOT_W  = 18;
  localparam int CBRT_STEPS = ROOT_W;
  localparam int REM_W   = 42;
  localparam int LX_W    = 23;
  localparam int F_W     = 17;
  localparam int RAW_W   = 28;
  localparam int L_W     = 15;
  localparam int AB_W    = 16;

  // pipeline stage numbers
  localparam int STG_LIN  = 0;
  localparam int STG_PROD = 1;
  localparam int STG_XYZ  = 2;
  localparam int STG_CB0  = 3;
  localparam int STG_CBL  = STG_CB0 + CBRT_STEPS - 1;
  localparam int STG_F    = STG_CBL + 1;
  localparam int STG_RAW  = STG_F + 1;
  localparam int STG_OUT  = STG_RAW + 1;
  localparam int NSTG     = STG_OUT + 1;

  localparam logic [XYZ_W-1:0] CUBE_THRESH = XYZ_W'(580);
  localparam logic [LX_W-1:0]  LIN_SLOPE   = LX_W'(7787);
  localparam logic [LX_W-1:0]  LIN_BIAS    = LX_W'(500);
  // ceil(2^32 / 1000), exact floor division for the linear branch range
  localparam logic [LX_W-1:0]  RECIP_1000  = LX_W'(4294968);
  localparam int               RECIP_SHIFT = 32;
  localparam logic [LX_W-1:0]  LIN_OFFSET  = LX_W'(9039);
  localparam int               ROUND_Q16   = 32768;

  localparam logic [COEF_W-1:0] MAT_Q16 [9] = '{
    16'd28440, 16'd24656, 16'd12442,
    16'd13938, 16'd46868, 16'd4730,
    16'd1164,  16'd7175,  16'd57202
  };

  typedef logic [LIN_W-1:0] lin_rom_t [256];

  typedef struct packed {
    logic [2:0]           big;
    logic [2:0][LX_W-1:0] lx;
  } side_t;

  function automatic longint unsigned mul_q30(input longint unsigned x,
                                              input longint unsigned y);
    return (x * y) >> 30;
  endfunction

  function automatic longint unsigned pow5_q30(input longint unsigned r);
    longint unsigned p;
    p = mul_q30(r, r);
    p = mul_q30(p, r);
    p = mul_q30(p, r);
    return mul_q30(p, r);
  endfunction

  // srgb gamma removal, unsigned q16
  function automatic lin_rom_t build_lin_rom();
    lin_rom_t        rom;
    longint unsigned c;
    longint unsigned t;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned v;
    int              k;
    for (c = 0; c < 256; c++) begin
      if (c <= 10) begin
        rom[c[7:0]] = LIN_W'((64'd6553600 * c + 64'd164730) / 64'd329460);
      end else begin
        t  = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
        lo = 0;
        hi = 64'd1 << 30;
        for (k = 0; k < 40; k++) begin
          if (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (pow5_q30(mid) <= t) lo = mid;
            else hi = mid - 64'd1;
          end
        end
        v = mul_q30(mul_q30(t, t), mul_q30(lo, lo));
        rom[c[7:0]] = LIN_W'((v + 64'd8192) >> 14);
      end
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

// ===== rtl/rgbl_if.sv =====
interface rgbl_pix_if import rgbl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbl_lab_if import rgbl_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [L_W-1:0]         lightness;
  logic signed [AB_W-1:0] green_red_axis;
  logic signed [AB_W-1:0] blue_yellow_axis;
  modport source (output valid, lightness, green_red_axis, blue_yellow_axis, input ready);
  modport sink   (input valid, lightness, green_red_axis, blue_yellow_axis, output ready);
endinterface

// ===== rtl/rgb_to_lab_pixel_top.sv =====
// sRGB (8 bits per channel) to CIELAB with D65 white. One pixel is accepted per clock while
// the skid register is empty, and results leave in order; the pipeline depth is set mostly
// by the cube root, which resolves one root bit per pipeline stage over 18 stages in each
// of three lanes. A skid register at the output lets the pipeline take one more pixel
// after the output stalls; input ready is the inverse of that skid's fill.
// L is unsigned and a, b are signed, all with FRAC_BITS fraction bits, rounded half away
// from zero and saturated.
module rgb_to_lab_pixel_top import rgbl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  rgbl_pix_if.sink   pix_i,
  rgbl_lab_if.source lab_o
);

  localparam int SH = 16 - FRAC_BITS;
  localparam logic [RAW_W-1:0]        HALF   = RAW_W'(1) << (SH - 1);
  localparam logic signed [RAW_W-1:0] SAT_HI = RAW_W'(32767);
  localparam logic signed [RAW_W-1:0] SAT_LO = -RAW_W'(32768);
  localparam logic signed [RAW_W-1:0] L_OFS  = RAW_W'(16 * 65536);

  logic            en;
  logic [NSTG-1:0] vld_q;

  logic [LIN_W-1:0]  lin_q  [3];
  logic [PROD_W-1:0] prod_q [9];
  logic [XYZ_W-1:0]  xyz_q  [3];
  side_t             side_q [STG_CB0:STG_CBL];
  logic [ROOT_W-1:0] root   [3];
  logic [F_W-1:0]    f_q    [3];

  logic signed [RAW_W-1:0] l_raw_q, a_raw_q, b_raw_q;
  logic [L_W-1:0]          l_q, l_d, skid_l_q;
  logic signed [AB_W-1:0]  a_q, a_d, skid_a_q;
  logic signed [AB_W-1:0]  b_q, b_d, skid_b_q;
  logic                    skid_vld_q;

  function automatic logic signed [RAW_W-1:0] round_q16(input logic signed [RAW_W-1:0] v);
    logic [RAW_W-1:0] mag;
    logic [RAW_W-1:0] m;
    mag = v[RAW_W-1] ? RAW_W'(-v) : RAW_W'(v);
    m   = (mag + HALF) >> SH;
    return v[RAW_W-1] ? -signed'(m) : signed'(m);
  endfunction

  assign en          = !skid_vld_q;
  assign pix_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], pix_i.valid};
    end
  end

  // gamma removal
  always_ff @(posedge clk_i) begin
    if (en) begin
      lin_q[0] <= LIN_ROM[pix_i.red];
      lin_q[1] <= LIN_ROM[pix_i.green];
      lin_q[2] <= LIN_ROM[pix_i.blue];
    end
  end

  // matrix products, white point folded in
  for (genvar k = 0; k < 9; k++) begin : g_prod
    always_ff @(posedge clk_i) begin
      if (en) begin
        prod_q[k] <= PROD_W'(MAT_Q16[k]) * PROD_W'(lin_q[k % 3]);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_xyz
    always_ff @(posedge clk_i) begin
      if (en) begin
        xyz_q[i] <= XYZ_W'((SUM_W'(prod_q[3*i]) + SUM_W'(prod_q[3*i+1])
                   + SUM_W'(prod_q[3*i+2]) + SUM_W'(ROUND_Q16)) >> 16);
      end
    end

    rgbl_cbrt u_cbrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .val_i  (xyz_q[i]),
      .root_o (root[i])
    );
  end

  // linear branch and branch select travel beside the cube root lanes
  for (genvar s = STG_CB0; s <= STG_CBL; s++) begin : g_side
    side_t side_d;
    if (s == STG_CB0) begin : g_lin_mul
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          side_d.big[i] = xyz_q[i] > CUBE_THRESH;
          side_d.lx[i]  = LIN_SLOPE * LX_W'(xyz_q[i][9:0]) + LIN_BIAS;
        end
      end
    end else if (s == STG_CB0 + 1) begin : g_lin_div
      always_comb begin
        side_d.big = side_q[s-1].big;
        for (int i = 0; i < 3; i++) begin
          side_d.lx[i] = LX_W'(((2*LX_W)'(side_q[s-1].lx[i]) * (2*LX_W)'(RECIP_1000))
                         >> RECIP_SHIFT) + LIN_OFFSET;
        end
      end
    end else begin : g_pass
      assign side_d = side_q[s-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[s] <= side_d;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_f
    always_ff @(posedge clk_i) begin
      if (en) begin
        f_q[i] <= side_q[STG_CBL].big[i]
                  ? F_W'(((ROOT_W+1)'(root[i]) + (ROOT_W+1)'(1)) >> 1)
                  : F_W'(side_q[STG_CBL].lx[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_raw_q <= signed'(RAW_W'(f_q[1])) * RAW_W'(116) - L_OFS;
      a_raw_q <= (signed'(RAW_W'(f_q[0])) - signed'(RAW_W'(f_q[1]))) * RAW_W'(500);
      b_raw_q <= (signed'(RAW_W'(f_q[1])) - signed'(RAW_W'(f_q[2]))) * RAW_W'(200);
    end
  end

  always_comb begin
    logic signed [RAW_W-1:0] lr;
    logic signed [RAW_W-1:0] ar;
    logic signed [RAW_W-1:0] br;
    lr = l_raw_q[RAW_W-1] ? '0 : round_q16(l_raw_q);
    ar = round_q16(a_raw_q);
    br = round_q16(b_raw_q);
    l_d = (lr > SAT_HI) ? L_W'(SAT_HI) : L_W'(lr);
    if (ar > SAT_HI) a_d = AB_W'(SAT_HI);
    else if (ar < SAT_LO) a_d = AB_W'(SAT_LO);
    else a_d = AB_W'(ar);
    if (br > SAT_HI) b_d = AB_W'(SAT_HI);
    else if (br < SAT_LO) b_d = AB_W'(SAT_LO);
    else b_d = AB_W'(br);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_q <= l_d;
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  // skid register behind the last stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en && vld_q[STG_OUT] && !lab_o.ready) begin
      skid_vld_q <= 1'b1;
    end else if (lab_o.ready) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[STG_OUT] && !lab_o.ready) begin
      skid_l_q <= l_q;
      skid_a_q <= a_q;
      skid_b_q <= b_q;
    end
  end

  assign lab_o.valid            = skid_vld_q | vld_q[STG_OUT];
  assign lab_o.lightness        = skid_vld_q ? skid_l_q : l_q;
  assign lab_o.green_red_axis   = skid_vld_q ? skid_a_q : a_q;
  assign lab_o.blue_yellow_axis = skid_vld_q ? skid_b_q : b_q;

endmodule

// ===== rtl/rgbl_cbrt.sv =====
module rgbl_cbrt import rgbl_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [XYZ_W-1:0]  val_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int TGT_W     = 3 * CBRT_STEPS;
  localparam int TGT_SHIFT = 35;

  logic [XYZ_W-1:0]    val_q [CBRT_STEPS-1];
  logic [2*ROOT_W-1:0] y2_q  [CBRT_STEPS-1];
  logic [REM_W-1:0]    rem_q [CBRT_STEPS-1];
  logic [ROOT_W-1:0]   y_q   [CBRT_STEPS];

  // one root bit per stage, restoring digit recurrence on val * 2^35
  for (genvar j = 0; j < CBRT_STEPS; j++) begin : g_step
    logic [XYZ_W-1:0]    val_in;
    logic [ROOT_W-1:0]   y_in;
    logic [ROOT_W-1:0]   y_dbl;
    logic [ROOT_W-1:0]   y_d;
    logic [2*ROOT_W-1:0] y2_in;
    logic [2*ROOT_W-1:0] y2_dbl;
    logic [2*ROOT_W-1:0] y2_d;
    logic [REM_W-1:0]    rem_in;
    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    yy_sum;
    logic [REM_W-1:0]    trial;
    logic [REM_W-1:0]    rem_d;
    logic [TGT_W-1:0]    tgt;

    if (j == 0) begin : g_first
      assign val_in = val_i;
      assign y_in   = '0;
      assign y2_in  = '0;
      assign rem_in = '0;
    end else begin : g_next
      assign val_in = val_q[j-1];
      assign y_in   = y_q[j-1];
      assign y2_in  = y2_q[j-1];
      assign rem_in = rem_q[j-1];
    end

    assign tgt = TGT_W'(val_in) << TGT_SHIFT;

    always_comb begin
      y_dbl  = {y_in[ROOT_W-2:0], 1'b0};
      y2_dbl = {y2_in[2*ROOT_W-3:0], 2'b00};
      rem_sh = {rem_in[REM_W-4:0], tgt[TGT_W-1-3*j -: 3]};
      yy_sum = REM_W'(y2_dbl) + REM_W'(y_dbl);
      trial  = (yy_sum << 1) + yy_sum + REM_W'(1);
      if (rem_sh >= trial) begin
        rem_d = rem_sh - trial;
        y_d   = y_dbl | ROOT_W'(1);
        y2_d  = y2_dbl + ((2*ROOT_W)'(y_dbl) << 1) + (2*ROOT_W)'(1);
      end else begin
        rem_d = rem_sh;
        y_d   = y_dbl;
        y2_d  = y2_dbl;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q[j] <= y_d;
      end
    end

    if (j < CBRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          val_q[j] <= val_in;
          y2_q[j]  <= y2_d;
          rem_q[j] <= rem_d;
        end
      end
    end
  end

  assign root_o = y_q[CBRT_STEPS-1];

endmodule

// ===== rtl/rgbl_checker.sv =====
`include "assert_macros.svh"

module rgbl_checker import rgbl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   pix_valid_i,
  input logic                   pix_ready_i,
  input logic                   lab_valid_i,
  input logic                   lab_ready_i,
  input logic [L_W-1:0]         lightness_i,
  input logic signed [AB_W-1:0] green_red_axis_i,
  input logic signed [AB_W-1:0] blue_yellow_axis_i
);

  localparam int L_MAX_I = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
  localparam logic [L_W-1:0] L_MAX = L_W'(L_MAX_I);
  localparam int CNT_W = $clog2(NSTG + 2) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NSTG + 1);

  logic             in_xfer;
  logic             out_xfer;
  logic [CNT_W-1:0] cnt_q;

  assign in_xfer  = pix_valid_i && pix_ready_i;
  assign out_xfer = lab_valid_i && lab_ready_i;

  // pixels taken in and not yet handed out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (out_xfer && !in_xfer) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  `RGBL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, lab_valid_i && !lab_ready_i, lab_valid_i && $stable(lightness_i) && $stable(green_red_axis_i) && $stable(blue_yellow_axis_i))
  `RGBL_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, lab_valid_i, cnt_q != '0)
  `RGBL_ASSERT_IMP(a_depth, clk_i, rst_ni, 1'b1, cnt_q <= CNT_MAX)
  `RGBL_ASSERT_IMP(a_l_range, clk_i, rst_ni, lab_valid_i, lightness_i <= L_MAX)

endmodule

bind rgb_to_lab_pixel_top rgbl_checker #(.FRAC_BITS(FRAC_BITS)) u_rgbl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .pix_valid_i        (pix_i.valid),
  .pix_ready_i        (pix_i.ready),
  .lab_valid_i        (lab_o.valid),
  .lab_ready_i        (lab_o.ready),
  .lightness_i        (lab_o.lightness),
  .green_red_axis_i   (lab_o.green_red_axis),
  .blue_yellow_axis_i (lab_o.blue_yellow_axis)
);

// ===== test/rgb_to_lab_pixel_top_tb.sv =====
module rgb_to_lab_pixel_top_tb import rgbl_pkg::*; ();
  localparam int FB      = FRAC_BITS_DEF;
  localparam int N_RAND  = 1830;
  localparam int LIMIT   = 400000;
  localparam int LAT     = 24;

  typedef struct {
    logic [CHAN_W-1:0] r, g, b;
    bit                known;
    logic [L_W-1:0]    l;
    logic [AB_W-1:0]   a, bb;
  } pix_row_t;

  typedef struct {
    logic [L_W-1:0]  l;
    logic [AB_W-1:0] a, b;
  } lab_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rgbl_pix_if pix ();
  rgbl_lab_if lab ();

  rgb_to_lab_pixel_top #(.FRAC_BITS(FB)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix),
    .lab_o (lab)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  longint unsigned gamma_lut [256];
  lab_t            lab_expected [$];
  int              errors = 0;
  int              cycles = 0;
  bit              calm = 1'b0;
  bit              hold_long = 1'b0;
  bit              stim_done = 1'b0;

  function automatic longint unsigned q30_mul(longint unsigned x, longint unsigned y);
    return (x * y) >> 30;
  endfunction

  task automatic fill_gamma_lut();
    longint unsigned t, lo, hi, mid, p, v;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        gamma_lut[c] = (64'd6553600 * c + 64'd164730) / 64'd329460;
      end else begin
        t  = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          p = q30_mul(q30_mul(q30_mul(q30_mul(mid, mid), mid), mid), mid);
          if (p <= t) lo = mid;
          else hi = mid - 1;
        end
        v = q30_mul(q30_mul(t, t), q30_mul(lo, lo));
        gamma_lut[c] = (v + 64'd8192) >> 14;
      end
    end
  endtask

  function automatic longint lab_compand(longint unsigned v);
    longint unsigned tgt, lo, hi, mid;
    if (v > 580) begin
      tgt = v << 35;
      lo = 0;
      hi = 64'd1 << 18;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * mid <= tgt) lo = mid;
        else hi = mid - 1;
      end
      return longint'((lo + 1) >> 1);
    end
    return longint'((7787 * v + 500) / 1000 + 9039);
  endfunction

  function automatic longint q16_to_frac(longint v);
    int     sh = 16 - FB;
    longint half = longint'(1) << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic lab_t srgb_to_lab(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint unsigned lin [3];
    longint unsigned xyz [3];
    longint          f [3];
    longint          l, a, bb;
    lab_t            res;
    lin[0] = gamma_lut[r];
    lin[1] = gamma_lut[g];
    lin[2] = gamma_lut[b];
    for (int i = 0; i < 3; i++) begin
      xyz[i] = (MAT_Q16[3*i] * lin[0] + MAT_Q16[3*i+1] * lin[1]
               + MAT_Q16[3*i+2] * lin[2] + 64'd32768) >> 16;
      f[i] = lab_compand(xyz[i]);
    end
    l = 116 * f[1] - 16 * 65536;
    if (l < 0) l = 0;
    l = q16_to_frac(l);
    if (l > 32767) l = 32767;
    a  = clip16(q16_to_frac(500 * (f[0] - f[1])));
    bb = clip16(q16_to_frac(200 * (f[1] - f[2])));
    res.l = l[L_W-1:0];
    res.a = a[AB_W-1:0];
    res.b = bb[AB_W-1:0];
    return res;
  endfunction

  pix_row_t directed [] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, 15'd0,     16'd0, 16'd0},
    '{8'd255, 8'd255, 8'd255, 1'b0, '0, '0, '0},
    '{8'd255, 8'd0,   8'd0,   1'b0, '0, '0, '0},
    '{8'd0,   8'd255, 8'd0,   1'b0, '0, '0, '0},
    '{8'd0,   8'd0,   8'd255, 1'b0, '0, '0, '0},
    '{8'd255, 8'd255, 8'd0,   1'b0, '0, '0, '0},
    '{8'd255, 8'd0,   8'd255, 1'b0, '0, '0, '0},
    '{8'd0,   8'd255, 8'd255, 1'b0, '0, '0, '0},
    '{8'd10,  8'd10,  8'd10,  1'b0, '0, '0, '0},
    '{8'd11,  8'd11,  8'd11,  1'b0, '0, '0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0, '0, '0},
    '{8'd0,   8'd1,   8'd0,   1'b0, '0, '0, '0},
    '{8'd0,   8'd0,   8'd1,   1'b0, '0, '0, '0},
    '{8'd3,   8'd3,   8'd3,   1'b0, '0, '0, '0},
    '{8'd6,   8'd6,   8'd6,   1'b0, '0, '0, '0},
    '{8'd128, 8'd128, 8'd128, 1'b0, '0, '0, '0},
    '{8'd170, 8'd85,  8'd170, 1'b0, '0, '0, '0},
    '{8'd85,  8'd170, 8'd85,  1'b0, '0, '0, '0},
    '{8'd255, 8'd0,   8'd128, 1'b0, '0, '0, '0},
    '{8'd0,   8'd128, 8'd255, 1'b0, '0, '0, '0}
  };

  // sender
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit have, lab_t ex);
    int   gap;
    lab_t want;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    want = have ? ex : srgb_to_lab(r, g, b);
    lab_expected.insert(lab_expected.size(), want);
  endtask

  initial begin
    lab_t ex;
    logic [7:0] r, g, b;
    int mode;
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    fill_gamma_lut();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      ex.l = directed[i].l;
      ex.a = directed[i].a;
      ex.b = directed[i].bb;
      send_pixel(directed[i].r, directed[i].g, directed[i].b, directed[i].known, ex);
    end
    for (int n = 0; n < N_RAND; n++) begin
      if (n == 300) hold_long = 1'b1;
      if (n == N_RAND - 200) calm = 1'b1;
      mode = $urandom_range(0, 3);
      r = CHAN_W'($urandom); g = CHAN_W'($urandom); b = CHAN_W'($urandom);
      if (mode == 0) begin
        r = CHAN_W'($urandom_range(0, 16));
        g = CHAN_W'($urandom_range(0, 16));
        b = CHAN_W'($urandom_range(0, 16));
      end else if (mode == 1) begin
        g = r; b = r;
      end
      send_pixel(r, g, b, 1'b0, ex);
    end
    pix.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver, with one long hold-off to back the pipeline up
  initial begin
    int gap;
    lab.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        lab.ready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 7);
        lab.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      lab.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // checker
  always @(posedge clk_i) begin
    lab_t ex;
    if (rst_ni && lab.valid && lab.ready) begin
      if (lab_expected.size() == 0) begin
        $error("unexpected transfer: L %0d", lab.lightness);
        errors++;
      end else begin
        ex = lab_expected.pop_front();
        if (lab.lightness !== ex.l) begin
          $error("lightness: expected %0d actual %0d", ex.l, lab.lightness);
          errors++;
        end
        if (lab.green_red_axis !== ex.a) begin
          $error("green_red_axis: expected %0d actual %0d",
                 $signed(ex.a), lab.green_red_axis);
          errors++;
        end
        if (lab.blue_yellow_axis !== ex.b) begin
          $error("blue_yellow_axis: expected %0d actual %0d",
                 $signed(ex.b), lab.blue_yellow_axis);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (lab_expected.size() != 0) @(posedge clk_i);
    repeat (LAT + 8) @(posedge clk_i);
    if (errors == 0 && lab_expected.size() == 0) begin
      $display("[rgb_to_lab_pixel_top] OK");
    end else begin
      $display("[rgb_to_lab_pixel_top] ERROR");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[rgb_to_lab_pixel_top] ERROR");
      $finish;
    end
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rgbl_pkg.sv
rtl/rgbl_if.sv
rtl/rgbl_cbrt.sv
rtl/rgb_to_lab_pixel_top.sv
rtl/rgbl_checker.sv
test/rgb_to_lab_pixel_top_tb.sv
